// ----- rtl/bpfa_pkg.sv -----
// ----------------------------------------------------------------------------
// bpfa_pkg: shared types and codes of the bitmap page frame allocator
// Request and response item layouts, operation and status codes, and the
// default geometry of the frame bitmap.
// ----------------------------------------------------------------------------
package bpfa_pkg;

   // Default geometry
   localparam int DEF_NUM_FRAMES    = 65536;
   localparam int DEF_PAGE_SHIFT    = 12;
   localparam int DEF_MAP_WORD_BITS = 32;

   // Width of frame arithmetic (frame numbers, byte addresses, sums)
   localparam int WIDE_BITS = 40;
   // Width of the run length carried across map words
   localparam int RUN_BITS  = 18;

   // Operation codes
   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_ALLOC  = 2'd1;
   localparam logic [1:0] OP_FREE   = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_SHORT = 2'd1;
   localparam logic [1:0] STAT_NORUN = 2'd2;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] address;
      logic [16:0] frame_count;
      logic [31:0] region_length;
      logic        region_available;
   } req_type;

   typedef struct packed {
      logic [27:0] alloc_address;
      logic [1:0]  status;
      logic [16:0] free_frames;
      logic [16:0] total_frames;
   } rsp_type;

endpackage

// ----- rtl/bitmap_page_frame_allocator.sv -----
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator: first-fit contiguous page frame allocator
// Keeps a used-frame bitmap in one synchronous memory plus counters of total
// and free frames; serves add-region, allocate and free items.
// ----------------------------------------------------------------------------
// After reset the block writes every bitmap word to all ones, one word per
// cycle, through all MAP_WORDS words (2048 by default), before the first item
// is taken. One item is processed at a time and gives one response item.
// Items that touch no frames (ignored regions, short or zero allocations,
// unused operation) go straight to the finish state. Add and free walk the
// bitmap memory from word 0 with one read-modify-write per cycle up to the
// last word of the range. Allocate scans the memory one word per cycle until
// the run is found, then walks again from word 0 to mark the run used. The
// single memory port pair (one read, one write per cycle) sets the pace of
// these walks. A new item is taken while the previous response still waits
// at the output.
module bitmap_page_frame_allocator #(
   parameter int NUM_FRAMES    = bpfa_pkg::DEF_NUM_FRAMES,
   parameter int PAGE_SHIFT    = bpfa_pkg::DEF_PAGE_SHIFT,
   parameter int MAP_WORD_BITS = bpfa_pkg::DEF_MAP_WORD_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bpfa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bpfa_pkg::rsp_type rsp_data
);
   import bpfa_pkg::*;

   localparam int MAP_WORDS = (NUM_FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int WIDX      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int WCNT      = $clog2(MAP_WORDS + 1);
   localparam int CNTW      = $clog2(NUM_FRAMES + 1);
   localparam int BITW      = $clog2(MAP_WORD_BITS);
   localparam int LOW       = $clog2(MAP_WORD_BITS + 1);

   localparam logic [WIDE_BITS-1:0] N_WIDE    = WIDE_BITS'(NUM_FRAMES);
   localparam logic [WIDE_BITS-1:0] W_WIDE    = WIDE_BITS'(MAP_WORD_BITS);
   localparam logic [WCNT-1:0]      WORDS_CNT = WCNT'(MAP_WORDS);
   localparam logic [WCNT-1:0]      LAST_CNT  = WCNT'(MAP_WORDS - 1);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCAN,
      ST_RANGE,
      ST_FINISH
   } state_type;

   state_type state_ff;

   // Bitmap memory and its ports
   logic [MAP_WORD_BITS-1:0] map_mem [MAP_WORDS];
   logic [MAP_WORD_BITS-1:0] rdata_ff;
   logic                     mem_we;
   logic [WIDX-1:0]          mem_wa;
   logic [WIDX-1:0]          mem_ra;
   logic [MAP_WORD_BITS-1:0] mem_wd;

   // Walk control
   logic [WCNT-1:0]      cnt_ff;
   logic                 issued_ff;
   logic [WCNT-1:0]      proc_ff;
   logic [WIDE_BITS-1:0] base_ff;
   logic [RUN_BITS-1:0]  run_ff;
   logic                 set_ff;
   logic [WIDE_BITS-1:0] fs_ff;
   logic [WIDE_BITS-1:0] fe_ff;
   logic [16:0]          count_ff;

   // Counters and pending result
   logic [CNTW-1:0] free_ff;
   logic [CNTW-1:0] ram_ff;
   logic [27:0]     res_addr_ff;
   logic [1:0]      res_status_ff;
   logic            rsp_valid_ff;
   rsp_type         rsp_ff;

   // Highest set bit of a word
   function automatic logic [BITW-1:0] hi_bit(input logic [MAP_WORD_BITS-1:0] v);
      logic [BITW-1:0] r;
      r = '0;
      for (int j = 0; j < MAP_WORD_BITS; j++) begin
         if (v[j]) begin
            r = BITW'(j);
         end
      end
      return r;
   endfunction

   // Saturating add at the frame count
   function automatic logic [WIDE_BITS-1:0] sat_add(input logic [WIDE_BITS-1:0] a,
                                                    input logic [WIDE_BITS-1:0] b);
      logic [WIDE_BITS-1:0] s;
      s = a + b;
      return (s > N_WIDE) ? N_WIDE : s;
   endfunction

   // Request decode: frame range and counter updates
   logic [WIDE_BITS-1:0] req_fs;
   logic [WIDE_BITS-1:0] req_pages;
   logic [WIDE_BITS-1:0] req_cnt_w;
   logic [WIDE_BITS-1:0] add_fe;
   logic [WIDE_BITS-1:0] free_fe;
   logic [WIDE_BITS-1:0] free_w;
   logic [WIDE_BITS-1:0] ram_w;
   logic [WIDE_BITS-1:0] free_add_in;
   logic [WIDE_BITS-1:0] ram_add_in;
   logic [WIDE_BITS-1:0] free_rel_in;
   logic [WIDE_BITS-1:0] free_alloc_in;

   always_comb begin
      req_fs    = WIDE_BITS'(req_data.address) >> PAGE_SHIFT;
      req_pages = (WIDE_BITS'(req_data.region_length)
                   + (WIDE_BITS'(1) << PAGE_SHIFT) - WIDE_BITS'(1)) >> PAGE_SHIFT;
      req_cnt_w = WIDE_BITS'(req_data.frame_count);
      add_fe    = req_fs + req_pages;
      if (add_fe > N_WIDE) begin
         add_fe = N_WIDE;
      end
      free_fe = req_fs + req_cnt_w;
      if (free_fe > N_WIDE) begin
         free_fe = N_WIDE;
      end
      free_w        = WIDE_BITS'(free_ff);
      ram_w         = WIDE_BITS'(ram_ff);
      free_add_in   = sat_add(free_w, req_pages);
      ram_add_in    = sat_add(ram_w, req_pages);
      free_rel_in   = sat_add(free_w, req_cnt_w);
      free_alloc_in = free_w - WIDE_BITS'(count_ff);
   end

   // Scan one map word for the end of a free run
   logic                 scan_found;
   logic [BITW-1:0]      scan_pos;
   logic [RUN_BITS-1:0]  run_in;
   logic [WIDE_BITS-1:0] start_in;

   always_comb begin
      logic [MAP_WORD_BITS-1:0] used_le;
      logic [RUN_BITS-1:0]      run_i;
      scan_found = 1'b0;
      scan_pos   = '0;
      run_in     = run_ff;
      for (int i = 0; i < MAP_WORD_BITS; i++) begin
         used_le = rdata_ff & ({MAP_WORD_BITS{1'b1}} >> (MAP_WORD_BITS - 1 - i));
         if (used_le == '0) begin
            run_i = run_ff + RUN_BITS'(i + 1);
         end else begin
            run_i = RUN_BITS'(i) - RUN_BITS'(hi_bit(used_le));
         end
         if (!scan_found && (run_i >= RUN_BITS'(count_ff))) begin
            scan_found = 1'b1;
            scan_pos   = BITW'(i);
         end
         if (i == MAP_WORD_BITS - 1) begin
            run_in = run_i;
         end
      end
      start_in = base_ff + WIDE_BITS'(scan_pos) + WIDE_BITS'(1) - WIDE_BITS'(count_ff);
   end

   // Range mask of the word being walked
   logic [LOW-1:0]           lo_off;
   logic [LOW-1:0]           hi_off;
   logic [MAP_WORD_BITS-1:0] range_mask;
   logic [MAP_WORD_BITS-1:0] range_word;
   logic [WIDE_BITS-1:0]     lo_diff;
   logic [WIDE_BITS-1:0]     hi_diff;

   always_comb begin
      lo_diff = fs_ff - base_ff;
      hi_diff = fe_ff - base_ff;
      if (fs_ff <= base_ff) begin
         lo_off = '0;
      end else if (lo_diff >= W_WIDE) begin
         lo_off = LOW'(MAP_WORD_BITS);
      end else begin
         lo_off = lo_diff[LOW-1:0];
      end
      if (fe_ff <= base_ff) begin
         hi_off = '0;
      end else if (hi_diff >= W_WIDE) begin
         hi_off = LOW'(MAP_WORD_BITS);
      end else begin
         hi_off = hi_diff[LOW-1:0];
      end
      for (int j = 0; j < MAP_WORD_BITS; j++) begin
         range_mask[j] = (LOW'(j) >= lo_off) && (LOW'(j) < hi_off);
      end
      range_word = set_ff ? (rdata_ff | range_mask) : (rdata_ff & ~range_mask);
   end

   // Memory port control
   always_comb begin
      mem_ra = cnt_ff[WIDX-1:0];
      mem_we = 1'b0;
      mem_wa = proc_ff[WIDX-1:0];
      mem_wd = range_word;
      if (state_ff == ST_INIT) begin
         mem_we = 1'b1;
         mem_wa = cnt_ff[WIDX-1:0];
         mem_wd = {MAP_WORD_BITS{1'b1}};
      end else if (state_ff == ST_RANGE) begin
         mem_we = issued_ff;
      end
   end

   // Bitmap memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_wa] <= mem_wd;
      end
      rdata_ff <= map_mem[mem_ra];
   end

   // Sequencer, counters and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         issued_ff    <= 1'b0;
         proc_ff      <= '0;
         free_ff      <= '0;
         ram_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_INIT: begin
               cnt_ff <= cnt_ff + WCNT'(1);
               if (cnt_ff == LAST_CNT) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               cnt_ff        <= '0;
               issued_ff     <= 1'b0;
               proc_ff       <= '0;
               base_ff       <= '0;
               run_ff        <= '0;
               count_ff      <= req_data.frame_count;
               res_addr_ff   <= '0;
               res_status_ff <= STAT_OK;
               if (req_valid) begin
                  state_ff <= ST_FINISH;
                  unique case (req_data.operation)
                     OP_ADD: begin
                        if (req_data.region_available) begin
                           free_ff <= free_add_in[CNTW-1:0];
                           ram_ff  <= ram_add_in[CNTW-1:0];
                           set_ff  <= 1'b0;
                           fs_ff   <= req_fs;
                           fe_ff   <= add_fe;
                           if (req_fs < add_fe) begin
                              state_ff <= ST_RANGE;
                           end
                        end
                     end
                     OP_ALLOC: begin
                        if (req_cnt_w > free_w) begin
                           res_status_ff <= STAT_SHORT;
                        end else if (req_data.frame_count != '0) begin
                           state_ff <= ST_SCAN;
                        end
                     end
                     OP_FREE: begin
                        free_ff <= free_rel_in[CNTW-1:0];
                        set_ff  <= 1'b0;
                        fs_ff   <= req_fs;
                        fe_ff   <= free_fe;
                        if (req_fs < free_fe) begin
                           state_ff <= ST_RANGE;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               // advance the read pointer; process the word read last cycle
               if (cnt_ff < WORDS_CNT) begin
                  cnt_ff    <= cnt_ff + WCNT'(1);
                  issued_ff <= 1'b1;
               end else begin
                  issued_ff <= 1'b0;
               end
               if (issued_ff) begin
                  proc_ff <= proc_ff + WCNT'(1);
                  base_ff <= base_ff + W_WIDE;
                  run_ff  <= run_in;
                  if (scan_found) begin
                     // mark the run used with a second walk from word 0
                     state_ff    <= ST_RANGE;
                     set_ff      <= 1'b1;
                     fs_ff       <= start_in;
                     fe_ff       <= start_in + WIDE_BITS'(count_ff);
                     res_addr_ff <= 28'(start_in << PAGE_SHIFT);
                     free_ff     <= free_alloc_in[CNTW-1:0];
                     cnt_ff      <= '0;
                     issued_ff   <= 1'b0;
                     proc_ff     <= '0;
                     base_ff     <= '0;
                  end else if (proc_ff == LAST_CNT) begin
                     res_status_ff <= STAT_NORUN;
                     state_ff      <= ST_FINISH;
                  end
               end
            end
            ST_RANGE: begin
               if (cnt_ff < WORDS_CNT) begin
                  cnt_ff    <= cnt_ff + WCNT'(1);
                  issued_ff <= 1'b1;
               end else begin
                  issued_ff <= 1'b0;
               end
               if (issued_ff) begin
                  proc_ff <= proc_ff + WCNT'(1);
                  base_ff <= base_ff + W_WIDE;
                  if ((base_ff + W_WIDE >= fe_ff) || (proc_ff == LAST_CNT)) begin
                     state_ff <= ST_FINISH;
                  end
               end
            end
            ST_FINISH: begin
               // hand the item over once the output register is free
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff         <= 1'b1;
                  rsp_ff.alloc_address <= res_addr_ff;
                  rsp_ff.status        <= res_status_ff;
                  rsp_ff.free_frames   <= free_w[16:0];
                  rsp_ff.total_frames  <= ram_w[16:0];
                  state_ff             <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_w <= N_WIDE)
      else $error("free count above frame count");

   a_ram_bound: assert property (@(posedge clock) disable iff (reset)
      ram_w <= N_WIDE)
      else $error("total count above frame count");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside finish");

   a_init_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INIT) |=> (state_ff == ST_INIT || state_ff == ST_IDLE))
      else $error("left clearing pass early");

endmodule
